// File: sv/wsdfr_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
package wsdfr_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TOO_SHORT = 2'd1;
  localparam logic [1:0] ERR_TRUNC     = 2'd2;

  // 7-bit length escapes
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Extended length and key byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // Result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } wsdfr_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        fin;
    logic [2:0]  rsv_bits;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] frame_len;
    logic [31:0] mask_key;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic [1:0]  error_code;
  } wsdfr_res_t;

  // Results produced by one accepted byte; second implies first.
  typedef struct packed {
    logic first;
    logic second;
  } wsdfr_push_t;

endpackage

// File: sv/wsdfr_parse.sv
// Header decode, length/key capture and payload unmasking, one byte per cycle while accept is high.
// Depends on wsdfr_pkg.
module wsdfr_parse
  import wsdfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  wsdfr_in_t   item,
  output wsdfr_push_t push,
  output wsdfr_res_t  row0,
  output wsdfr_res_t  row1
);

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SKIP    = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  hdr_count, hdr_count_next;
  logic [8:0]  flags, flags_next;        // fin, rsv[2:0], opcode[3:0], masked
  logic [63:0] length, length_next;
  logic [63:0] remaining, remaining_next;
  logic [31:0] key, key_next;
  logic [1:0]  key_idx, key_idx_next;

  logic        do_hdr, do_pay, do_err;
  logic [1:0]  err_code;
  logic [7:0]  pay_byte;
  logic        pay_last;
  logic [7:0]  b;
  logic        last_in;

  function automatic wsdfr_res_t err_row(input logic [1:0] code);
    wsdfr_res_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  assign b       = item.data_byte;
  assign last_in = item.buffer_end;

  always_comb begin
    phase_next     = phase;
    hdr_count_next = hdr_count;
    flags_next     = flags;
    length_next    = length;
    remaining_next = remaining;
    key_next       = key;
    key_idx_next   = key_idx;
    do_hdr         = 1'b0;
    do_pay         = 1'b0;
    do_err         = 1'b0;
    err_code       = ERR_TRUNC;
    pay_byte       = b ^ key[{~key_idx, 3'b000} +: 8];
    pay_last       = 1'b0;
    push           = '0;
    row0           = '0;
    row1           = '0;

    unique case (phase)
      PH_SECOND: begin
        flags_next  = {flags[8:1], b[7]};
        length_next = '0;
        if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
          hdr_count_next = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          if (last_in) do_err = 1'b1;
          else phase_next = PH_EXTLEN;
        end else begin
          length_next = {57'd0, b[6:0]};
          if (b[7]) begin
            hdr_count_next = KEY_BYTES;
            if (last_in) do_err = 1'b1;
            else phase_next = PH_KEY;
          end else begin
            do_hdr = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        length_next    = {length[55:0], b};
        hdr_count_next = hdr_count - 4'd1;
        if (hdr_count_next != 4'd0) begin
          if (last_in) do_err = 1'b1;
        end else if (flags[0]) begin
          hdr_count_next = KEY_BYTES;
          if (last_in) do_err = 1'b1;
          else phase_next = PH_KEY;
        end else begin
          do_hdr = 1'b1;
        end
      end
      PH_KEY: begin
        key_next       = {key[23:0], b};
        hdr_count_next = hdr_count - 4'd1;
        if (hdr_count_next != 4'd0) begin
          if (last_in) do_err = 1'b1;
        end else begin
          do_hdr = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        key_idx_next   = key_idx + 2'd1;
        remaining_next = remaining - 64'd1;
        do_pay         = 1'b1;
        pay_last       = (remaining_next == 64'd0);
        if (pay_last) phase_next = last_in ? PH_FIRST : PH_SKIP;
        else if (last_in) do_err = 1'b1;
      end
      PH_SKIP: begin
        if (last_in) phase_next = PH_FIRST;
      end
      default: begin
        flags_next     = {b, 1'b0};
        hdr_count_next = '0;
        length_next    = '0;
        remaining_next = '0;
        key_next       = '0;
        key_idx_next   = '0;
        if (last_in) begin
          do_err   = 1'b1;
          err_code = ERR_TOO_SHORT;
        end else begin
          phase_next = PH_SECOND;
        end
      end
    endcase

    if (do_pay) begin
      row0.kind          = KIND_PAYLOAD;
      row0.payload_byte  = pay_byte;
      row0.last_of_frame = pay_last;
    end

    if (do_hdr) begin
      row0.kind          = KIND_HEADER;
      row0.fin           = flags_next[8];
      row0.rsv_bits      = flags_next[7:5];
      row0.opcode        = flags_next[4:1];
      row0.masked        = flags_next[0];
      row0.frame_len     = length_next;
      row0.mask_key      = key_next;
      row0.last_of_frame = (length_next == 64'd0);
      key_idx_next       = '0;
      if (length_next == 64'd0) begin
        phase_next = last_in ? PH_FIRST : PH_SKIP;
      end else begin
        remaining_next = length_next;
        if (last_in) do_err = 1'b1;
        else phase_next = PH_PAYLOAD;
      end
    end

    // An error either stands alone or follows the header/payload request.
    if (do_err) begin
      phase_next = PH_FIRST;
      if (do_hdr || do_pay) begin
        row1        = err_row(err_code);
        push.second = accept;
      end else begin
        row0 = err_row(err_code);
      end
    end

    push.first = accept && (do_hdr || do_pay || do_err);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      hdr_count <= '0;
      flags     <= '0;
      length    <= '0;
      remaining <= '0;
      key       <= '0;
      key_idx   <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      hdr_count <= hdr_count_next;
      flags     <= flags_next;
      length    <= length_next;
      remaining <= remaining_next;
      key       <= key_next;
      key_idx   <= key_idx_next;
    end
  end

endmodule

// File: sv/wsdfr_queue.sv
// Small result queue: takes up to two results per cycle, hands out one unless stalled.
// Depends on wsdfr_pkg.
module wsdfr_queue
  import wsdfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  wsdfr_push_t push,
  input  wsdfr_res_t  row0,
  input  wsdfr_res_t  row1,
  output logic        room,
  output logic        valid,
  input  logic        stall,
  output wsdfr_res_t  data
);

  wsdfr_res_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count, count_next;
  logic                pop;

  assign valid = (count != '0);
  assign pop   = valid && !stall;
  assign data  = entries[rd_ptr];
  // Always leave space for the two-result case.
  assign room  = (count <= QCNT_W'(QUEUE_DEPTH - 2));

  assign count_next = count + QCNT_W'(push.first) + QCNT_W'(push.second)
                      - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.first) entries[wr_ptr] <= row0;
    if (push.second) entries[wr_ptr + QPTR_W'(1)] <= row1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.first) + QPTR_W'(push.second);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count_next;
    end
  end

endmodule

// File: sv/websocket_frame_deframer_core.sv
// WebSocket frame deframer top level: byte parser feeding a result queue.
// A byte's results are registered in the result queue and reach res_item in order.
// Throughput: one byte per cycle while rx_stall is low; a byte ending a buffer may add a second result.
// rx_stall rises while the four-entry result queue has fewer than two free slots.
// Reset (rst, synchronous) returns the parser to the first header byte and
// empties the queue. Depends on wsdfr_pkg, wsdfr_parse, wsdfr_queue.
module websocket_frame_deframer_core
  import wsdfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  wsdfr_in_t  rx_item,
  output logic       res_valid,
  input  logic       res_stall,
  output wsdfr_res_t res_item
);

  wsdfr_push_t push;
  wsdfr_res_t  row0, row1;
  logic        room;
  logic        rx_accept;

  assign rx_stall  = !room;
  assign rx_accept = rx_valid && room;

  wsdfr_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .accept (rx_accept),
    .item   (rx_item),
    .push   (push),
    .row0   (row0),
    .row1   (row1)
  );

  wsdfr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .row0  (row0),
    .row1  (row1),
    .room  (room),
    .valid (res_valid),
    .stall (res_stall),
    .data  (res_item)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for websocket_frame_deframer_core: a byte-level
// predictor of the frame parser checks every result. Directed buffers come
// first, then random frames (well-formed, truncated and noise) under random
// sender bursts and receiver stalls.
// Depends on wsdfr_pkg and the deframer RTL.
module tb_top;
  import wsdfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_FIRST, PH_SECOND, PH_EXTLEN, PH_KEY, PH_PAYLOAD, PH_SKIP
  } parse_phase_t;

  typedef logic [7:0] octet_q_t[$];

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       rx_valid  = 1'b0;
  logic       rx_stall;
  wsdfr_in_t  rx_item   = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  wsdfr_res_t res_item;

  websocket_frame_deframer_core u_top (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_item   (rx_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  always #4 clk = ~clk;

  // Parser shadow state
  parse_phase_t phase_q = PH_FIRST;
  logic [3:0]   hdr_left = '0;
  logic         fin_q = 1'b0;
  logic [2:0]   rsv_q = '0;
  logic [3:0]   opcode_q = '0;
  logic         masked_q = 1'b0;
  logic [63:0]  length_q = '0;
  logic [63:0]  remain_q = '0;
  logic [31:0]  key_q = '0;
  logic [1:0]   key_idx = '0;

  wsdfr_res_t expected_results[$];
  wsdfr_res_t want;
  int         err_count = 0;
  int         sent_total = 0;
  int         burst_left = 0;
  int         stall_mode = 0;
  int         stall_left = 0;

  task automatic expect_error(logic [1:0] code);
    wsdfr_res_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    expected_results.push_back(r);
    phase_q = PH_FIRST;
  endtask

  task automatic expect_header(logic last_in_buf);
    wsdfr_res_t r;
    r = '0;
    r.kind = KIND_HEADER;
    r.fin = fin_q;
    r.rsv_bits = rsv_q;
    r.opcode = opcode_q;
    r.masked = masked_q;
    r.frame_len = length_q;
    r.mask_key = key_q;
    r.last_of_frame = (length_q == 0);
    expected_results.push_back(r);
    key_idx = '0;
    if (length_q == 0) begin
      phase_q = last_in_buf ? PH_FIRST : PH_SKIP;
    end else begin
      remain_q = length_q;
      if (last_in_buf) expect_error(ERR_TRUNC);
      else phase_q = PH_PAYLOAD;
    end
  endtask

  // After the length is known: key next, or the header is complete.
  task automatic length_complete(logic last_in_buf);
    if (masked_q) begin
      hdr_left = KEY_BYTES;
      if (last_in_buf) expect_error(ERR_TRUNC);
      else phase_q = PH_KEY;
    end else begin
      expect_header(last_in_buf);
    end
  endtask

  task automatic deframe_predict(logic [7:0] d, logic last_in_buf);
    wsdfr_res_t r;
    logic [7:0] kb;
    case (phase_q)
      PH_SECOND: begin
        masked_q = d[7];
        length_q = '0;
        if (d[6:0] == LEN_EXT16 || d[6:0] == LEN_EXT64) begin
          hdr_left = (d[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          if (last_in_buf) expect_error(ERR_TRUNC);
          else phase_q = PH_EXTLEN;
        end else begin
          length_q = 64'(d[6:0]);
          length_complete(last_in_buf);
        end
      end
      PH_EXTLEN: begin
        length_q = {length_q[55:0], d};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left != 0) begin
          if (last_in_buf) expect_error(ERR_TRUNC);
        end else begin
          length_complete(last_in_buf);
        end
      end
      PH_KEY: begin
        key_q = {key_q[23:0], d};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left != 0) begin
          if (last_in_buf) expect_error(ERR_TRUNC);
        end else begin
          expect_header(last_in_buf);
        end
      end
      PH_PAYLOAD: begin
        kb = 8'(key_q >> ((3 - key_idx) * 8));
        key_idx = key_idx + 2'd1;
        remain_q = remain_q - 64'd1;
        r = '0;
        r.kind = KIND_PAYLOAD;
        r.payload_byte = d ^ kb;
        r.last_of_frame = (remain_q == 0);
        expected_results.push_back(r);
        if (remain_q == 0) phase_q = last_in_buf ? PH_FIRST : PH_SKIP;
        else if (last_in_buf) expect_error(ERR_TRUNC);
      end
      PH_SKIP: begin
        if (last_in_buf) phase_q = PH_FIRST;
      end
      default: begin
        fin_q = d[7];
        rsv_q = d[6:4];
        opcode_q = d[3:0];
        masked_q = 1'b0;
        hdr_left = '0;
        length_q = '0;
        remain_q = '0;
        key_q = '0;
        key_idx = '0;
        if (last_in_buf) expect_error(ERR_TOO_SHORT);
        else phase_q = PH_SECOND;
      end
    endcase
  endtask

  // One request: hold until accepted, then maybe open a gap between bursts.
  task automatic send_byte(logic [7:0] d, logic last_in_buf);
    rx_valid <= 1'b1;
    rx_item <= '{data_byte: d, buffer_end: last_in_buf};
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    deframe_predict(d, last_in_buf);
    sent_total++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic send_buffer(octet_q_t bq);
    foreach (bq[i]) send_byte(bq[i], i == bq.size() - 1);
  endtask

  task automatic wait_results_drained();
    rx_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Random frame; a broken one may declare a huge length and is cut at a random point.
  task automatic send_frame(bit broken);
    octet_q_t    fq;
    logic [63:0] declared;
    logic [6:0]  len7;
    int          sel;
    int          ext_n;
    int          nbytes;
    int          cut;
    logic        is_masked;
    fq.push_back(8'($urandom));
    is_masked = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 9);
    ext_n = 0;
    if (sel < 7) declared = 64'($urandom_range(0, 12));
    else if (sel == 7) declared = 64'($urandom_range(0, 125));
    else if (broken) declared = {$urandom, $urandom};
    else declared = 64'($urandom_range(0, 40));
    if (sel == 8) begin
      ext_n = 2;
      declared = 64'(declared[15:0]);
      len7 = LEN_EXT16;
    end else if (sel == 9) begin
      ext_n = 8;
      len7 = LEN_EXT64;
    end else begin
      len7 = declared[6:0];
    end
    fq.push_back({is_masked, len7});
    for (int i = ext_n - 1; i >= 0; i--) fq.push_back(declared[8*i +: 8]);
    if (is_masked) repeat (4) fq.push_back(8'($urandom));
    nbytes = (broken && declared > 24) ? 24 : int'(declared);
    repeat (nbytes) fq.push_back(8'($urandom));
    if (broken) begin
      cut = $urandom_range(1, fq.size());
      fq = fq[0:cut-1];
    end else if ($urandom_range(0, 3) == 0) begin
      // trailing bytes past the payload
      repeat ($urandom_range(1, 3)) fq.push_back(8'($urandom));
    end
    send_buffer(fq);
  endtask

  task automatic test_directed();
    send_buffer('{8'hFF});
    send_buffer('{8'h00, 8'h7E});
    send_buffer('{8'h81, 8'h05});
    send_buffer('{8'h89, 8'h00, 8'hAA, 8'h55});
    send_buffer('{8'h02, 8'h7E, 8'h00, 8'h01, 8'h5A, 8'h00});
    // 64-bit length with top bit set, masked, ends inside the payload
    send_buffer('{8'h82, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h03, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h12});
  endtask

  task automatic test_good_frames(int quota);
    int stop_at;
    stop_at = sent_total + quota;
    while (sent_total < stop_at) send_frame(1'b0);
  endtask

  task automatic test_broken_frames(int quota);
    int stop_at;
    stop_at = sent_total + quota;
    while (sent_total < stop_at) send_frame(($urandom_range(0, 3) != 0));
  endtask

  task automatic test_noise(int quota);
    repeat (quota) send_byte(8'($urandom), ($urandom_range(0, 5) == 0));
  endtask

  // Receiver stall pattern: modes from never to mostly stalled
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(50, 300);
      end
      stall_left--;
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 3) == 0);
        2: res_stall <= 1'($urandom_range(0, 1));
        default: res_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: kind %0d", res_item.kind);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", want.kind, res_item.kind);
        check_field("fin", want.fin, res_item.fin);
        check_field("rsv_bits", want.rsv_bits, res_item.rsv_bits);
        check_field("opcode", want.opcode, res_item.opcode);
        check_field("masked", want.masked, res_item.masked);
        check_field("frame_len", want.frame_len, res_item.frame_len);
        check_field("mask_key", want.mask_key, res_item.mask_key);
        check_field("payload_byte", want.payload_byte, res_item.payload_byte);
        check_field("last_of_frame", want.last_of_frame, res_item.last_of_frame);
        check_field("error_code", want.error_code, res_item.error_code);
      end
    end
  end

  initial begin
    #5ms;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_results_drained();
    test_good_frames(750);
    wait_results_drained();
    test_broken_frames(300);
    test_noise(100);
    test_good_frames(100);
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
